>>> hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // classified work handed from front to back; count is entries after the beat
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  value;
        logic [CNT_W-1:0]          count;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        status_t                   status;
        logic [CNT_W-1:0]          entries;
    } res_t;

endpackage

>>> hw/rtl/mhpq_front.sv
`timescale 1ns / 1ps
// Front end: accepts beats, classifies them against a running count, queues commands.
module mhpq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           op,
    input  logic signed [31:0]             value,
    output logic                           cmd_valid,
    input  logic                           cmd_pop,
    output mhpq_pkg::cmd_t                 cmd
);
    import mhpq_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             q_mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             accept;
    cmd_t             new_cmd;

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // count runs ahead of the back end; the heap work follows in order
    always_comb
    begin
        count_next     = count_reg;
        new_cmd.value  = value;
        new_cmd.status = ST_PUSHED;
        if (op == OP_PUSH)
        begin
            if (count_reg == CNT_W'(CAPACITY))
            begin
                new_cmd.status = ST_FULL;
            end
            else
            begin
                new_cmd.status = ST_PUSHED;
                count_next     = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                new_cmd.status = ST_EMPTY;
            end
            else
            begin
                new_cmd.status = ST_POPPED;
                count_next     = count_reg - CNT_W'(1);
            end
        end
        new_cmd.count = count_next;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({accept, cmd_pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> hw/rtl/mhpq_back.sv
`timescale 1ns / 1ps
// Back end: heap memory and the sift-up / sift-down sequencer.
module mhpq_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_pop,
    input  mhpq_pkg::cmd_t                 cmd,
    input  logic                           res_full,
    output logic                           res_push,
    output mhpq_pkg::res_t                 res
);
    import mhpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP       = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_POP_ROOT = 8'b0000_1000,
        S_POP_CUR  = 8'b0001_0000,
        S_DN       = 8'b0010_0000,
        S_DN_L     = 8'b0100_0000,
        S_DN_R     = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    status_t                   status_reg, status_next;
    logic signed [DATA_W-1:0]  cur_reg, cur_next;
    logic signed [DATA_W-1:0]  lv_reg, lv_next;
    logic signed [DATA_W-1:0]  popped_reg, popped_next;

    logic signed [DATA_W-1:0]  heap_mem [CAPACITY];
    logic signed [DATA_W-1:0]  rd_data_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;

    logic [ADDR_W-1:0]         parent;
    logic [CNT_W:0]            left_w;
    logic [CNT_W:0]            right_w;
    logic [CNT_W:0]            n_w;
    logic [CNT_W-1:0]          cnt_m1;
    logic signed [DATA_W-1:0]  big_val;
    logic [ADDR_W-1:0]         big_pos;

    assign parent  = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_w  = {{(CNT_W - ADDR_W){1'b0}}, pos_reg, 1'b1};
    assign right_w = left_w + (CNT_W + 1)'(1);
    assign n_w     = {1'b0, count_reg};
    assign cnt_m1  = cmd.count - CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        status_next = status_reg;
        cur_next    = cur_reg;
        lv_next     = lv_reg;
        popped_next = popped_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = cur_reg;
        mem_raddr   = '0;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res.popped_value = popped_reg;
        res.status       = status_reg;
        res.entries      = count_reg;
        big_val     = cur_reg;
        big_pos     = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                // result room is checked here; only this unit fills the result queue
                if (cmd_valid && !res_full)
                begin
                    cmd_pop     = 1'b1;
                    count_next  = cmd.count;
                    status_next = cmd.status;
                    popped_next = '0;
                    cur_next    = cmd.value;
                    case (cmd.status)
                        ST_PUSHED:
                        begin
                            pos_next   = cnt_m1[ADDR_W-1:0];
                            state_next = S_UP;
                        end
                        ST_POPPED:
                        begin
                            mem_raddr  = '0;
                            state_next = S_POP_ROOT;
                        end
                        default:
                        begin
                            // full push or empty pop: answer at once
                            res_push         = 1'b1;
                            res.popped_value = '0;
                            res.status       = cmd.status;
                            res.entries      = cmd.count;
                        end
                    endcase
                end
            end

            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (rd_data_reg >= cur_reg)
                begin
                    mem_we     = 1'b1;
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rd_data_reg;
                    pos_next   = parent;
                    state_next = S_UP;
                end
            end

            S_POP_ROOT:
            begin
                popped_next = rd_data_reg;
                if (count_reg == '0)
                begin
                    res_push         = 1'b1;
                    res.popped_value = rd_data_reg;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mem_raddr  = count_reg[ADDR_W-1:0];
                    state_next = S_POP_CUR;
                end
            end

            S_POP_CUR:
            begin
                // last entry becomes the value carried down from the root
                cur_next   = rd_data_reg;
                pos_next   = '0;
                state_next = S_DN;
            end

            S_DN:
            begin
                if (left_w < n_w)
                begin
                    mem_raddr  = left_w[ADDR_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    mem_we     = 1'b1;
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DN_L:
            begin
                lv_next = rd_data_reg;
                if (right_w < n_w)
                begin
                    mem_raddr  = right_w[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
                else if (rd_data_reg > cur_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rd_data_reg;
                    pos_next   = left_w[ADDR_W-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    mem_we     = 1'b1;
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DN_R:
            begin
                // left wins ties between children
                if (lv_reg > cur_reg)
                begin
                    big_val = lv_reg;
                    big_pos = left_w[ADDR_W-1:0];
                end
                if (rd_data_reg > big_val)
                begin
                    big_val = rd_data_reg;
                    big_pos = right_w[ADDR_W-1:0];
                end
                mem_we = 1'b1;
                if (big_pos == pos_reg)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_wdata  = big_val;
                    pos_next   = big_pos;
                    state_next = S_DN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        cur_reg    <= cur_next;
        lv_reg     <= lv_next;
        popped_reg <= popped_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= heap_mem[mem_raddr];
    end

endmodule

>>> hw/rtl/mhpq_out_q.sv
`timescale 1ns / 1ps
// Two-entry result queue feeding the output ports.
module mhpq_out_q (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_push,
    input  mhpq_pkg::res_t                 res,
    output logic                           res_full,
    input  logic                           pop,
    output logic                           empty,
    output mhpq_pkg::res_t                 res_out
);
    import mhpq_pkg::*;

    res_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       take;

    assign res_full = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign res_out  = q_mem_reg[rd_ptr_reg];
    assign take     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        case ({res_push, take})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> hw/rtl/max_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue of 256 signed 32-bit entries, one result per beat.
// Each input beat is a push (op 0) or a pop of the largest value (op 1) and yields
// one result: popped value, status and the entry count after the beat. A front end
// classifies beats against its own running count into a two-entry command queue,
// so up to two beats are taken ahead of the heap work. The heap lives in a single
// memory with one read and one write port; that port sets the pace. A push climbs
// past strictly smaller parents; a pop that leaves entries moves the last one to the
// root and sifts it down, left child winning ties; a dropped push or an empty pop
// is answered at once.
// Results wait in a two-entry output queue; no clearing pass is needed after reset.
module max_heap_priority_queue_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                op,
    input  logic signed [31:0]  value,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  popped_value,
    output logic [1:0]          status,
    output logic [8:0]          entries
);
    import mhpq_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    logic res_push;
    logic res_full;
    res_t res;
    res_t res_out;

    mhpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    mhpq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    mhpq_out_q u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign popped_value = res_out.popped_value;
    assign status       = res_out.status;
    assign entries      = res_out.entries;

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    a_cmd_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty command queue");

    a_entries_cap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (entries <= 9'(CAPACITY)))
        else $error("entry count above capacity");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_POPPED)) |-> (popped_value == '0))
        else $error("nonzero value on a result that removed nothing");

endmodule

>>> tb/max_heap_priority_queue_unit_checker.sv
`timescale 1ns / 1ps
// Heap predictor and result checker for the max-heap priority queue unit.
module max_heap_priority_queue_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               op,
    input  logic signed [31:0] value,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] popped_value,
    input  logic [1:0]         status,
    input  logic [8:0]         entries,
    output int                 mismatches,
    output int                 outstanding
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] heap_mem [CAPACITY];
    int unsigned              heap_count;
    res_t                     awaited_beats [$];

    // Applies one beat to the shadow heap and returns the result it yields.
    function automatic res_t apply_beat(input logic beat_op,
                                        input logic signed [DATA_W-1:0] beat_value);
        res_t                     r;
        int unsigned              pos;
        int unsigned              parent;
        int unsigned              left;
        int unsigned              right;
        int unsigned              big;
        logic signed [DATA_W-1:0] tmp;
        logic                     done;
        r.popped_value = '0;
        if (beat_op == OP_PUSH) begin
            if (heap_count >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                pos = heap_count;
                heap_count++;
                done = 1'b0;
                // climb only past strictly smaller parents
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (heap_mem[parent] >= beat_value) begin
                        done = 1'b1;
                    end
                    else begin
                        heap_mem[pos] = heap_mem[parent];
                        pos = parent;
                    end
                end
                heap_mem[pos] = beat_value;
                r.status = ST_PUSHED;
            end
        end
        else if (heap_count == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            r.popped_value = heap_mem[0];
            heap_count--;
            heap_mem[0] = heap_mem[heap_count];
            pos = 0;
            done = 1'b0;
            // left child wins ties; swap only when a child is strictly greater
            while (!done) begin
                left  = 2 * pos + 1;
                right = left + 1;
                big   = pos;
                if (left < heap_count && heap_mem[left] > heap_mem[big])
                    big = left;
                if (right < heap_count && heap_mem[right] > heap_mem[big])
                    big = right;
                if (big == pos) begin
                    done = 1'b1;
                end
                else begin
                    tmp           = heap_mem[pos];
                    heap_mem[pos] = heap_mem[big];
                    heap_mem[big] = tmp;
                    pos           = big;
                end
            end
            r.status = ST_POPPED;
        end
        r.entries = CNT_W'(heap_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n) begin
            heap_count  = 0;
            mismatches  = 0;
            awaited_beats.delete();
            outstanding <= 0;
        end
        else begin
            if (push && !full)
                awaited_beats.push_back(apply_beat(op, value));
            if (pop && !empty) begin
                if (awaited_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected: popped_value %0d status %0d entries %0d",
                             $time, popped_value, status, entries);
                end
                else begin
                    want = awaited_beats.pop_front();
                    if (popped_value !== want.popped_value) begin
                        mismatches++;
                        $display("%0t: popped_value expected %0d got %0d",
                                 $time, want.popped_value, popped_value);
                    end
                    if (status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, status);
                    end
                    if (entries !== want.entries) begin
                        mismatches++;
                        $display("%0t: entries expected %0d got %0d",
                                 $time, want.entries, entries);
                    end
                end
            end
            outstanding <= awaited_beats.size();
        end
    end

endmodule

>>> tb/max_heap_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// Top-level testbench: push/pop stimulus, backpressure and verdict for the heap queue.
module max_heap_priority_queue_unit_test;
    import mhpq_pkg::*;

    localparam int RANDOM_ITEMS = 1730;
    localparam int TOTAL_ITEMS  = RANDOM_ITEMS + 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 64;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               op    = OP_PUSH;
    logic signed [31:0] value = '0;
    logic               pop   = 1'b0;
    logic               full;
    logic               empty;
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [8:0]         entries;

    int mismatches;
    int outstanding;
    int send_gap_pct = 31;
    int take_gap_pct = 59;
    int beats_sent   = 0;
    int cycle_count  = 0;

    max_heap_priority_queue_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .popped_value (popped_value),
        .status       (status),
        .entries      (entries)
    );

    max_heap_priority_queue_unit_checker heap_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .popped_value (popped_value),
        .status       (status),
        .entries      (entries),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("max_heap_priority_queue_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= take_gap_pct);
    end

    // mix of full-range words, extremes, a narrow band that forces ties and a wider band around zero
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(8)) - 4;
            7:
            begin
                case ($urandom_range(3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000000;
                    default: return 32'shffffffff;
                endcase
            end
            default:    return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    task automatic offer_beat(input logic beat_op, input logic signed [31:0] beat_value);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push  <= 1'b0;
            op    <= 1'($urandom_range(1));
            value <= $urandom;
            @(posedge clk);
        end
        push  <= 1'b1;
        op    <= beat_op;
        value <= beat_value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_sent++;
        // backpressure phases: receiver-heavy gaps, then sender-heavy, then none
        if (beats_sent == TOTAL_ITEMS / 3)
        begin
            send_gap_pct = 59;
            take_gap_pct = 31;
        end
        else if (beats_sent == 2 * TOTAL_ITEMS / 3)
        begin
            send_gap_pct = 0;
            take_gap_pct = 0;
        end
    endtask

    initial
    begin
        int seg;
        int seg_len;
        int push_pct;
        int sent_random;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, ties, drain past empty
        offer_beat(OP_POP,  32'sh12345678);
        offer_beat(OP_PUSH, 32'sh00000000);
        offer_beat(OP_PUSH, 32'sh80000000);
        offer_beat(OP_PUSH, 32'sh7fffffff);
        offer_beat(OP_PUSH, 32'shffffffff);
        offer_beat(OP_PUSH, 32'sh00000001);
        offer_beat(OP_PUSH, 32'sh00000005);
        offer_beat(OP_PUSH, 32'sh00000005);
        offer_beat(OP_PUSH, 32'sh00000005);
        offer_beat(OP_POP,  32'shffffffff);
        offer_beat(OP_POP,  32'sh00000000);
        offer_beat(OP_PUSH, 32'sh7fffffff);
        offer_beat(OP_POP,  32'sh80000000);
        offer_beat(OP_POP,  32'sh55555555);
        offer_beat(OP_POP,  32'shaaaaaaaa);
        offer_beat(OP_POP,  32'sh00000000);
        offer_beat(OP_POP,  32'sh00000000);
        offer_beat(OP_POP,  32'sh00000000);
        offer_beat(OP_POP,  32'sh00000000);
        offer_beat(OP_POP,  32'sh00000000);

        // random: first fill past capacity, then drain past empty, then mixed runs
        seg = 0;
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            if (seg == 0)
            begin
                seg_len  = 330;
                push_pct = 95;
            end
            else if (seg == 1)
            begin
                seg_len  = 330;
                push_pct = 5;
            end
            else
            begin
                seg_len = $urandom_range(400, 40);
                case ($urandom_range(2))
                    0:       push_pct = 88;
                    1:       push_pct = 12;
                    default: push_pct = 50;
                endcase
            end
            for (int i = 0; i < seg_len && sent_random < RANDOM_ITEMS; i++)
            begin
                offer_beat(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, pick_value());
                sent_random++;
            end
            seg++;
        end
        push <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("max_heap_priority_queue_unit: match");
        else
            $display("max_heap_priority_queue_unit: mismatch");
        $finish;
    end

endmodule
